/* rtl/contiguous_segment_allocator_macros.svh */
// Assertion macros shared by the segment allocator RTL.
// No dependencies; included by files that carry concurrent assertions.
`ifndef CONTIGUOUS_SEGMENT_ALLOCATOR_MACROS_SVH
`define CONTIGUOUS_SEGMENT_ALLOCATOR_MACROS_SVH

// same-cycle implication
`define CSA_ASSERT_NOW(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("segment allocator check failed");

// next-cycle implication
`define CSA_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("segment allocator check failed");

`endif

/* rtl/csa_pkg.sv */
// Package for the contiguous segment allocator: widths, codes, types.
// No dependencies.
package csa_pkg;

   localparam int LEN_W      = 16;
   localparam int PID_W      = 8;
   localparam int STAT_W     = 3;
   localparam int RESULT_CAP = 16;

   localparam int DEF_MAX_SEGMENTS = 16;
   localparam int DEF_ADDR_BITS    = 16;

   localparam logic [LEN_W-1:0] TOTAL_RESET = 16'd4096;

   // register map: index is paddr[2]
   localparam logic REG_TOTAL_SIZE = 1'b0;

   typedef enum logic [1:0] {
      OP_ALLOC   = 2'd0,
      OP_RELEASE = 2'd1,
      OP_COMPACT = 2'd2,
      OP_STATUS  = 2'd3
   } op_type;

   localparam logic [1:0] STRAT_FIRST = 2'd0;  // 'F'
   localparam logic [1:0] STRAT_BEST  = 2'd1;  // 'B'
   localparam logic [1:0] STRAT_WORST = 2'd2;  // 'W'

   localparam logic [STAT_W-1:0] ST_OK       = 3'd0;
   localparam logic [STAT_W-1:0] ST_NO_FIT   = 3'd1;
   localparam logic [STAT_W-1:0] ST_NO_OWNER = 3'd2;
   localparam logic [STAT_W-1:0] ST_FULL     = 3'd3;
   localparam logic [STAT_W-1:0] ST_BAD_SIZE = 3'd4;

   typedef struct packed {
      logic [LEN_W-1:0] start;
      logic [LEN_W-1:0] len;
      logic [PID_W-1:0] owner;
      logic             used;
   } seg_entry_type;

   typedef struct packed {
      logic [STAT_W-1:0] status;
      logic [LEN_W-1:0]  seg_addr;
      logic [LEN_W-1:0]  seg_len;
      logic [PID_W-1:0]  seg_owner;
      logic              seg_in_use;
      logic              last;
   } rsp_type;

   typedef enum logic [4:0] {
      S_INIT,
      S_IDLE,
      S_AL_RD, S_AL_EV, S_AL_CHK, S_AL_HI, S_AL_LO,
      S_RL_RD, S_RL_EV, S_RL_NRD, S_RL_NEV, S_RL_PRD, S_RL_PEV, S_RL_WR,
      S_CP_RD, S_CP_EV, S_CP_END,
      S_ST_RD, S_ST_EM,
      S_MV_RD, S_MV_WR,
      S_RESP
   } csa_state_type;

endpackage

/* rtl/csa_if.sv */
// Valid/ready channel interfaces for request and response transactions.
// Depends on csa_pkg.
interface csa_req_if import csa_pkg::*; ;
   logic             valid;
   logic             ready;
   logic [1:0]       op;
   logic [PID_W-1:0] process_id;
   logic [LEN_W-1:0] req_size;
   logic [1:0]       strategy;

   modport source (output valid, op, process_id, req_size, strategy, input ready);
   modport sink   (input valid, op, process_id, req_size, strategy, output ready);
endinterface

interface csa_rsp_if import csa_pkg::*; ;
   logic              valid;
   logic              ready;
   logic [STAT_W-1:0] status;
   logic [LEN_W-1:0]  seg_addr;
   logic [LEN_W-1:0]  seg_len;
   logic [PID_W-1:0]  seg_owner;
   logic              seg_in_use;
   logic              last;

   modport source (output valid, status, seg_addr, seg_len, seg_owner, seg_in_use, last,
                   input ready);
   modport sink   (input valid, status, seg_addr, seg_len, seg_owner, seg_in_use, last,
                   output ready);
endinterface

/* rtl/csa_table.sv */
// Segment table memory: one write port, one read port with registered data.
// Depends on csa_pkg.
module csa_table import csa_pkg::*; #(
   parameter int MAX_SEGMENTS = DEF_MAX_SEGMENTS,
   localparam int IW = (MAX_SEGMENTS > 1) ? $clog2(MAX_SEGMENTS) : 1
) (
   input  logic          clock,
   input  logic          we,
   input  logic [IW-1:0] waddr,
   input  seg_entry_type wdata,
   input  logic [IW-1:0] raddr,
   output seg_entry_type rdata
);

   seg_entry_type mem [MAX_SEGMENTS];
   seg_entry_type rd_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
      rd_ff <= mem[raddr];
   end

   assign rdata = rd_ff;

endmodule

/* rtl/contiguous_segment_allocator.sv */
// Top level of the contiguous segment allocator: sequencer, CSR port, response register.
// Depends on csa_pkg, csa_if, csa_table and the assertion macro header.
//
//   channel  | dir | handshake        | carries
//   ---------+-----+------------------+-------------------------------------------
//   req_ch   | in  | valid/ready      | op, process_id, req_size, strategy
//   rsp_ch   | out | valid/ready      | status, seg_addr, seg_len, owner, in_use, last
//   csr      | in  | APB, pready = 1  | total_size at byte 0
//
// One transaction at a time. Each table step is a read then an evaluate or
// write, entry by entry, through the table's one read port and one write
// port; response stalls can hold a transaction in its final state.
// Reset (synchronous, active high) and a total_size write pass through an
// init state that rebuilds entry 0; req_ch.ready is low meanwhile.
// A stalled response holds in its register; the next request is taken anyway.
`include "contiguous_segment_allocator_macros.svh"

module contiguous_segment_allocator import csa_pkg::*; #(
   parameter int MAX_SEGMENTS = DEF_MAX_SEGMENTS,
   parameter int ADDR_BITS    = DEF_ADDR_BITS
) (
   input  logic        clock,
   input  logic        reset,
   csa_req_if.sink     req_ch,
   csa_rsp_if.source   rsp_ch,
   input  logic        psel,
   input  logic        penable,
   input  logic        pwrite,
   input  logic [2:0]  paddr,
   input  logic [31:0] pwdata,
   output logic [31:0] prdata,
   output logic        pready
);

   localparam int IW = (MAX_SEGMENTS > 1) ? $clog2(MAX_SEGMENTS) : 1;
   localparam int CW = $clog2(MAX_SEGMENTS + 1);
   localparam logic [CW-1:0] MAX_CNT  = CW'(MAX_SEGMENTS);
   localparam logic [CW-1:0] DUMP_CAP =
      (MAX_SEGMENTS > RESULT_CAP) ? CW'(RESULT_CAP) : CW'(MAX_SEGMENTS);
   // largest size the address range can hold
   localparam logic [LEN_W-1:0] SIZE_MAX =
      (ADDR_BITS >= LEN_W) ? {LEN_W{1'b1}} : LEN_W'((64'd1 << ADDR_BITS) - 64'd1);
   localparam logic [LEN_W-1:0] TOTAL_INIT =
      (TOTAL_RESET > SIZE_MAX) ? SIZE_MAX : TOTAL_RESET;

   // ---------------- state ----------------
   csa_state_type    state_ff, state_in;
   logic [LEN_W-1:0] total_ff;
   logic [CW-1:0]    cnt_ff;       // live segments
   logic [CW-1:0]    idx_ff;       // scan position
   logic [CW-1:0]    pick_ff;      // chosen / found entry
   logic             found_ff;
   logic [LEN_W-1:0] pk_start_ff, pk_len_ff;
   logic [PID_W-1:0] pid_ff;
   logic [LEN_W-1:0] size_ff;
   logic [1:0]       strat_ff;
   op_type           op_ff;
   logic [LEN_W-1:0] acc_ff;       // release: merged length; compact: next address
   logic [LEN_W-1:0] free_ff;      // compact: free total
   logic [CW-1:0]    n_ff;         // compact: write position
   logic             nxt_free_ff, prv_free_ff;
   logic [LEN_W-1:0] prv_start_ff, prv_len_ff;
   logic [CW-1:0]    mv_src_ff, mv_dst_ff, mv_end_ff;
   logic             mv_up_ff;
   csa_state_type    mv_ret_ff;
   rsp_type          res_ff;       // pending single result
   rsp_type          out_ff;
   logic             out_vld_ff;

   // ---------------- table ----------------
   logic          mem_we;
   logic [IW-1:0] mem_wa, mem_ra;
   seg_entry_type mem_wd, rd;

   csa_table #(.MAX_SEGMENTS(MAX_SEGMENTS)) u_table (
      .clock (clock),
      .we    (mem_we),
      .waddr (mem_wa),
      .wdata (mem_wd),
      .raddr (mem_ra),
      .rdata (rd)
   );

   // ---------------- handshakes ----------------
   logic req_acc, out_free, out_load, cfg_wr;
   rsp_type out_data;

   assign req_ch.ready = (state_ff == S_IDLE);
   assign req_acc      = req_ch.valid && req_ch.ready;
   assign out_free     = !out_vld_ff || rsp_ch.ready;
   assign cfg_wr       = psel && penable && pwrite && pready && (paddr[2] == REG_TOTAL_SIZE);
   assign pready       = 1'b1;
   assign prdata       = {{(32-LEN_W){1'b0}}, total_ff};

   // ---------------- scan decisions ----------------
   logic            al_fit, al_take, rl_hit, mv_done, st_last;
   logic [CW-1:0]   ndump;
   logic [1:0]      rl_k;

   assign al_fit  = !rd.used && (rd.len >= size_ff);
   assign al_take = al_fit &&
                    ((strat_ff == STRAT_FIRST) ||
                     ((strat_ff == STRAT_BEST)  && (!found_ff || rd.len < pk_len_ff)) ||
                     ((strat_ff == STRAT_WORST) && (!found_ff || rd.len > pk_len_ff)));
   assign rl_hit  = rd.used && (rd.owner == pid_ff);
   assign mv_done = mv_up_ff ? (mv_dst_ff == mv_end_ff) : (mv_src_ff == mv_end_ff);
   assign ndump   = (cnt_ff > DUMP_CAP) ? DUMP_CAP : cnt_ff;
   assign st_last = (CW'(idx_ff + 1'b1) == ndump);
   assign rl_k    = {1'b0, prv_free_ff} + {1'b0, nxt_free_ff};

   // ---------------- next state ----------------
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         S_INIT: state_in = S_IDLE;
         S_IDLE: begin
            if (req_acc) begin
               unique case (op_type'(req_ch.op))
                  OP_ALLOC:   state_in = (req_ch.req_size == '0) ? S_RESP : S_AL_RD;
                  OP_RELEASE: state_in = S_RL_RD;
                  OP_COMPACT: state_in = S_CP_RD;
                  OP_STATUS:  state_in = S_ST_RD;
                  default:    state_in = S_IDLE;
               endcase
            end
         end
         S_AL_RD:  state_in = (idx_ff == cnt_ff) ? S_AL_CHK : S_AL_EV;
         S_AL_EV:  state_in = (al_take && strat_ff == STRAT_FIRST) ? S_AL_CHK : S_AL_RD;
         S_AL_CHK: begin
            if (!found_ff || (pk_len_ff != size_ff && cnt_ff == MAX_CNT)) begin
               state_in = S_RESP;
            end else if (pk_len_ff == size_ff) begin
               state_in = S_AL_LO;
            end else begin
               state_in = S_MV_RD;
            end
         end
         S_AL_HI:  state_in = S_AL_LO;
         S_AL_LO:  state_in = S_RESP;
         S_RL_RD:  state_in = (idx_ff == cnt_ff) ? S_RESP : S_RL_EV;
         S_RL_EV:  state_in = rl_hit ? S_RL_NRD : S_RL_RD;
         S_RL_NRD: state_in = (CW'(pick_ff + 1'b1) < cnt_ff) ? S_RL_NEV : S_RL_PRD;
         S_RL_NEV: state_in = S_RL_PRD;
         S_RL_PRD: state_in = (pick_ff != '0) ? S_RL_PEV : S_RL_WR;
         S_RL_PEV: state_in = S_RL_WR;
         S_RL_WR:  state_in = (rl_k == 2'd0) ? S_RESP : S_MV_RD;
         S_CP_RD:  state_in = (idx_ff == cnt_ff) ? S_CP_END : S_CP_EV;
         S_CP_EV:  state_in = S_CP_RD;
         S_CP_END: state_in = S_RESP;
         S_ST_RD:  state_in = S_ST_EM;
         S_ST_EM: begin
            if (out_free) begin
               state_in = st_last ? S_IDLE : S_ST_RD;
            end
         end
         S_MV_RD:  state_in = mv_done ? mv_ret_ff : S_MV_WR;
         S_MV_WR:  state_in = S_MV_RD;
         S_RESP:   state_in = out_free ? S_IDLE : S_RESP;
         default:  state_in = S_INIT;
      endcase
      if (cfg_wr) begin
         state_in = S_INIT;
      end
   end

   // ---------------- table and response controls ----------------
   always_comb begin
      mem_we   = 1'b0;
      mem_wa   = '0;
      mem_wd   = '0;
      mem_ra   = idx_ff[IW-1:0];
      out_load = 1'b0;
      out_data = res_ff;
      unique case (state_ff)
         S_INIT: begin
            mem_we    = 1'b1;
            mem_wd.len = total_ff;
         end
         S_AL_HI: begin
            mem_we     = 1'b1;
            mem_wa     = IW'(pick_ff + 1'b1);
            mem_wd.start = pk_start_ff + size_ff;
            mem_wd.len   = pk_len_ff - size_ff;
         end
         S_AL_LO: begin
            mem_we       = 1'b1;
            mem_wa       = pick_ff[IW-1:0];
            mem_wd.start = pk_start_ff;
            mem_wd.len   = size_ff;
            mem_wd.owner = pid_ff;
            mem_wd.used  = 1'b1;
         end
         S_RL_NRD: mem_ra = IW'(pick_ff + 1'b1);
         S_RL_PRD: mem_ra = IW'(pick_ff - 1'b1);
         S_RL_WR: begin
            mem_we = 1'b1;
            if (prv_free_ff) begin
               mem_wa       = IW'(pick_ff - 1'b1);
               mem_wd.start = prv_start_ff;
               mem_wd.len   = prv_len_ff + acc_ff;
            end else begin
               mem_wa       = pick_ff[IW-1:0];
               mem_wd.start = res_ff.seg_addr;
               mem_wd.len   = acc_ff;
            end
         end
         S_CP_EV: begin
            mem_we       = rd.used;
            mem_wa       = n_ff[IW-1:0];
            mem_wd.start = acc_ff;
            mem_wd.len   = rd.len;
            mem_wd.owner = rd.owner;
            mem_wd.used  = 1'b1;
         end
         S_CP_END: begin
            mem_we       = (free_ff != '0) || (n_ff == '0);
            mem_wa       = n_ff[IW-1:0];
            mem_wd.start = acc_ff;
            mem_wd.len   = free_ff;
         end
         S_ST_EM: begin
            out_load            = out_free;
            out_data.status     = ST_OK;
            out_data.seg_addr   = rd.start;
            out_data.seg_len    = rd.len;
            out_data.seg_owner  = rd.used ? rd.owner : '0;
            out_data.seg_in_use = rd.used;
            out_data.last       = st_last;
         end
         S_MV_RD: mem_ra = mv_src_ff[IW-1:0];
         S_MV_WR: begin
            mem_we = 1'b1;
            mem_wa = mv_dst_ff[IW-1:0];
            mem_wd = rd;
         end
         S_RESP: begin
            out_load      = out_free;
            out_data.last = 1'b1;
         end
         default: ;
      endcase
   end

   // ---------------- control registers ----------------
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= S_INIT;
         total_ff   <= TOTAL_INIT;
         cnt_ff     <= CW'(1);
         out_vld_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         if (cfg_wr) begin
            total_ff <= (pwdata[LEN_W-1:0] > SIZE_MAX) ? SIZE_MAX : pwdata[LEN_W-1:0];
         end
         if (out_load) begin
            out_vld_ff <= 1'b1;
         end else if (rsp_ch.ready) begin
            out_vld_ff <= 1'b0;
         end
         unique case (state_ff)
            S_INIT:   cnt_ff <= CW'(1);
            S_AL_CHK: begin
               if (found_ff && pk_len_ff != size_ff && cnt_ff != MAX_CNT) begin
                  cnt_ff <= CW'(cnt_ff + 1'b1);
               end
            end
            S_RL_WR:  cnt_ff <= CW'(cnt_ff - rl_k);
            S_CP_END: begin
               cnt_ff <= ((free_ff != '0) || (n_ff == '0)) ? CW'(n_ff + 1'b1) : n_ff;
            end
            default: ;
         endcase
      end
   end

   // ---------------- datapath registers ----------------
   always_ff @(posedge clock) begin
      if (out_load) begin
         out_ff <= out_data;
      end
      case (state_ff)
         S_IDLE: begin
            op_ff    <= op_type'(req_ch.op);
            pid_ff   <= req_ch.process_id;
            size_ff  <= req_ch.req_size;
            strat_ff <= req_ch.strategy;
            idx_ff   <= '0;
            found_ff <= 1'b0;
            n_ff     <= '0;
            acc_ff   <= '0;
            free_ff  <= '0;
            res_ff   <= '{status: (op_type'(req_ch.op) == OP_ALLOC) ? ST_BAD_SIZE : ST_OK,
                          default: '0};
         end
         S_AL_EV: begin
            if (al_take) begin
               pick_ff     <= idx_ff;
               pk_start_ff <= rd.start;
               pk_len_ff   <= rd.len;
               found_ff    <= 1'b1;
            end
            idx_ff <= CW'(idx_ff + 1'b1);
         end
         S_AL_CHK: begin
            if (!found_ff) begin
               res_ff.status <= ST_NO_FIT;
            end else if (pk_len_ff != size_ff && cnt_ff == MAX_CNT) begin
               res_ff.status <= ST_FULL;
            end
            // open a hole at pick+1 by shifting the tail up one entry
            mv_up_ff  <= 1'b1;
            mv_dst_ff <= cnt_ff;
            mv_src_ff <= CW'(cnt_ff - 1'b1);
            mv_end_ff <= CW'(pick_ff + 1'b1);
            mv_ret_ff <= S_AL_HI;
         end
         S_AL_LO: begin
            res_ff.status     <= ST_OK;
            res_ff.seg_addr   <= pk_start_ff;
            res_ff.seg_len    <= size_ff;
            res_ff.seg_owner  <= pid_ff;
            res_ff.seg_in_use <= 1'b1;
         end
         S_RL_RD: begin
            if (idx_ff == cnt_ff) begin
               res_ff.status <= ST_NO_OWNER;
            end
         end
         S_RL_EV: begin
            if (rl_hit) begin
               pick_ff         <= idx_ff;
               res_ff.seg_addr <= rd.start;
               res_ff.seg_len  <= rd.len;
               acc_ff          <= rd.len;
            end
            idx_ff <= CW'(idx_ff + 1'b1);
         end
         S_RL_NRD: nxt_free_ff <= 1'b0;
         S_RL_NEV: begin
            if (!rd.used) begin
               nxt_free_ff <= 1'b1;
               acc_ff      <= acc_ff + rd.len;
            end
         end
         S_RL_PRD: prv_free_ff <= 1'b0;
         S_RL_PEV: begin
            prv_free_ff  <= !rd.used;
            prv_start_ff <= rd.start;
            prv_len_ff   <= rd.len;
         end
         S_RL_WR: begin
            // close the gap left by merged entries
            mv_up_ff  <= 1'b0;
            mv_dst_ff <= prv_free_ff ? pick_ff : CW'(pick_ff + 1'b1);
            mv_src_ff <= prv_free_ff ? CW'(pick_ff + rl_k) : CW'(pick_ff + 2'd2);
            mv_end_ff <= cnt_ff;
            mv_ret_ff <= S_RESP;
         end
         S_CP_EV: begin
            if (rd.used) begin
               acc_ff <= acc_ff + rd.len;
               n_ff   <= CW'(n_ff + 1'b1);
            end else begin
               free_ff <= free_ff + rd.len;
            end
            idx_ff <= CW'(idx_ff + 1'b1);
         end
         S_CP_END: begin
            res_ff.seg_addr <= acc_ff;
            res_ff.seg_len  <= free_ff;
         end
         S_ST_EM: begin
            if (out_free) begin
               idx_ff <= CW'(idx_ff + 1'b1);
            end
         end
         S_MV_WR: begin
            if (mv_up_ff) begin
               mv_src_ff <= CW'(mv_src_ff - 1'b1);
               mv_dst_ff <= CW'(mv_dst_ff - 1'b1);
            end else begin
               mv_src_ff <= CW'(mv_src_ff + 1'b1);
               mv_dst_ff <= CW'(mv_dst_ff + 1'b1);
            end
         end
         default: ;
      endcase
   end

   assign rsp_ch.valid      = out_vld_ff;
   assign rsp_ch.status     = out_ff.status;
   assign rsp_ch.seg_addr   = out_ff.seg_addr;
   assign rsp_ch.seg_len    = out_ff.seg_len;
   assign rsp_ch.seg_owner  = out_ff.seg_owner;
   assign rsp_ch.seg_in_use = out_ff.seg_in_use;
   assign rsp_ch.last       = out_ff.last;

   // ---------------- assertions ----------------
   `CSA_ASSERT_NOW(a_cnt_range, clock, reset, 1'b1, (cnt_ff != '0) && (cnt_ff <= MAX_CNT))
   `CSA_ASSERT_NOW(a_no_overwrite, clock, reset, out_load, (!out_vld_ff || rsp_ch.ready))
   `CSA_ASSERT_NEXT(a_busy_after_acc, clock, reset, req_acc, !req_ch.ready)
   `CSA_ASSERT_NEXT(a_cfg_rebuilds, clock, reset, cfg_wr, state_ff == S_INIT)

endmodule
